// ===== design/sjrp_pkg.sv =====
package sjrp_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int XY_W         = 27;
    localparam int TRIG_W       = 14;
    localparam int FRAC_BITS    = 12;
    localparam int MUL_STEPS    = 7;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 27'sd10188015;

    localparam logic signed [31:0] ATAN_TURN [CORDIC_STEPS] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41721,     32'sd20860
    };

    localparam logic [15:0] HALF_LINK_RESET    = 16'd1024;
    localparam logic [15:0] INVERSE_HALF_RESET = 16'd16384;

    typedef enum logic {
        REG_HALF_LINK    = 1'b0,
        REG_INVERSE_HALF = 1'b1
    } sjrp_reg_t;

    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_LOAD   = 3'd1,
        OP_ROT    = 3'd2,
        OP_TRIG   = 3'd3,
        OP_MUL    = 3'd4,
        OP_FINISH = 3'd5
    } sjrp_op_t;

    typedef struct packed {
        sjrp_op_t          op;
        logic [STEP_W-1:0] step;
    } sjrp_cmd_t;

    typedef struct packed {
        logic out_free;
    } sjrp_status_t;

endpackage

// ===== design/sjrp_if.sv =====
interface sjrp_in_if #(
    parameter int ANGLE_BITS    = 16,
    parameter int VELOCITY_BITS = 24
);
    logic                            valid;
    logic                            ready;
    logic signed [VELOCITY_BITS-1:0] head_linear_velocity;
    logic signed [VELOCITY_BITS-1:0] head_angular_velocity;
    logic signed [ANGLE_BITS-1:0]    joint_angle;
    logic                            start_of_chain;
    logic                            end_of_chain;

    modport source (
        output valid, head_linear_velocity, head_angular_velocity, joint_angle,
               start_of_chain, end_of_chain,
        input  ready
    );
    modport sink (
        input  valid, head_linear_velocity, head_angular_velocity, joint_angle,
               start_of_chain, end_of_chain,
        output ready
    );
endinterface

interface sjrp_out_if #(
    parameter int VELOCITY_BITS = 24
);
    logic                            valid;
    logic                            ready;
    logic signed [VELOCITY_BITS-1:0] joint_rate;
    logic                            chain_done;
    logic                            saturated;

    modport source (
        output valid, joint_rate, chain_done, saturated,
        input  ready
    );
    modport sink (
        input  valid, joint_rate, chain_done, saturated,
        output ready
    );
endinterface

// ===== design/sjrp_ctrl.sv =====
module sjrp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sjrp_pkg::sjrp_status_t status,
    output sjrp_pkg::sjrp_cmd_t    cmd
);
    import sjrp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ROT  = 5'b00010,
        S_TRIG = 5'b00100,
        S_MUL  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.op     = OP_NONE;
        cmd.step   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    cnt_next   = '0;
                    state_next = S_ROT;
                end
            end
            S_ROT:
            begin
                cmd.op   = OP_ROT;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(CORDIC_STEPS - 1))
                begin
                    state_next = S_TRIG;
                end
            end
            S_TRIG:
            begin
                cmd.op     = OP_TRIG;
                cnt_next   = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.op   = OP_MUL;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(MUL_STEPS - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_FINISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== design/sjrp_datapath.sv =====
module sjrp_datapath #(
    parameter int ANGLE_BITS    = 16,
    parameter int VELOCITY_BITS = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sjrp_pkg::sjrp_cmd_t              cmd,
    output sjrp_pkg::sjrp_status_t           status,
    input  logic signed [VELOCITY_BITS-1:0] head_linear_velocity,
    input  logic signed [VELOCITY_BITS-1:0] head_angular_velocity,
    input  logic signed [ANGLE_BITS-1:0]    joint_angle,
    input  logic                            start_of_chain,
    input  logic                            end_of_chain,
    input  logic [15:0]                     half_link_length,
    input  logic [15:0]                     inverse_half_link,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [VELOCITY_BITS-1:0] joint_rate,
    output logic                            chain_done,
    output logic                            saturated
);
    import sjrp_pkg::*;

    localparam int VB    = VELOCITY_BITS;
    localparam int MW    = (VB > 31) ? VB : 31;
    localparam int ACC_W = 2 * MW + 2;
    localparam int RND_W = ACC_W - 24;

    localparam logic signed [RND_W-1:0] RND_MAX = RND_W'({1'b0, {(VB-1){1'b1}}});
    localparam logic signed [RND_W-1:0] RND_MIN = -RND_MAX - RND_W'(1);
    localparam logic signed [VB:0]      DIF_MAX = (VB+1)'({1'b0, {(VB-1){1'b1}}});
    localparam logic signed [VB:0]      DIF_MIN = -DIF_MAX - (VB+1)'(1);
    localparam logic signed [VB-1:0]    V_MAX   = {1'b0, {(VB-1){1'b1}}};
    localparam logic signed [VB-1:0]    V_MIN   = {1'b1, {(VB-1){1'b0}}};

    logic signed [VB-1:0]     v_reg, w_reg, cv_reg, cw_reg, next_reg;
    logic                     eoc_reg, flip_reg, sat_reg;
    logic signed [XY_W-1:0]   x_reg, y_reg;
    logic signed [31:0]       z_reg;
    logic signed [TRIG_W-1:0] s_reg, c_reg;
    logic signed [2*MW-1:0]   prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     ovalid_reg, odone_reg, osat_reg;
    logic signed [VB-1:0]     orate_reg;

    logic signed [31:0]       z_load;
    logic signed [XY_W-1:0]   x_sh, y_sh;
    logic signed [XY_W-1:0]   x_rnd, y_rnd;
    logic signed [TRIG_W-1:0] c_new, s_new;
    logic signed [MW-1:0]     a_op, b_op;
    logic signed [2*MW-1:0]   prod_next;
    logic signed [ACC_W-1:0]  prod_ext, acc_bias;
    logic signed [RND_W-1:0]  rnd;
    logic signed [VB-1:0]     rnd_val, rate_val;
    logic                     rnd_sat, rate_sat;
    logic signed [VB:0]       diff;

    // CORDIC rotation step and load
    assign z_load = {joint_angle, {(32-ANGLE_BITS){1'b0}}};
    assign x_sh   = x_reg >>> cmd.step;
    assign y_sh   = y_reg >>> cmd.step;
    assign x_rnd  = (x_reg + XY_W'(2048)) >>> FRAC_BITS;
    assign y_rnd  = (y_reg + XY_W'(2048)) >>> FRAC_BITS;
    assign c_new  = flip_reg ? -x_rnd[TRIG_W-1:0] : x_rnd[TRIG_W-1:0];
    assign s_new  = flip_reg ? -y_rnd[TRIG_W-1:0] : y_rnd[TRIG_W-1:0];

    // shared multiplier operand select
    always_comb
    begin
        a_op = '0;
        b_op = '0;
        case (cmd.step)
            STEP_W'(0):
            begin
                a_op = MW'($signed({1'b0, inverse_half_link}));
                b_op = MW'(s_reg);
            end
            STEP_W'(1):
            begin
                a_op = prod_reg[MW-1:0];
                b_op = MW'(v_reg);
            end
            STEP_W'(2):
            begin
                a_op = MW'(w_reg);
                b_op = MW'(c_reg) + MW'(1 << FRAC_BITS);
            end
            STEP_W'(3):
            begin
                a_op = MW'(v_reg);
                b_op = MW'(c_reg);
            end
            STEP_W'(4):
            begin
                a_op = MW'($signed({1'b0, half_link_length}));
                b_op = MW'(s_reg);
            end
            STEP_W'(5):
            begin
                a_op = prod_reg[MW-1:0];
                b_op = MW'(w_reg);
            end
            default:
            begin
                a_op = '0;
                b_op = '0;
            end
        endcase
    end

    assign prod_next = a_op * b_op;
    assign prod_ext  = ACC_W'(prod_reg);

    // round half up from 2^-36 to Q12.12, then clip
    assign acc_bias = acc_reg + ACC_W'(1 << 23);
    assign rnd      = acc_bias[ACC_W-1:24];
    always_comb
    begin
        rnd_sat = 1'b1;
        if (rnd > RND_MAX)
        begin
            rnd_val = V_MAX;
        end
        else if (rnd < RND_MIN)
        begin
            rnd_val = V_MIN;
        end
        else
        begin
            rnd_val = rnd[VB-1:0];
            rnd_sat = 1'b0;
        end
    end

    assign diff = (VB+1)'(next_reg) - (VB+1)'(w_reg);
    always_comb
    begin
        rate_sat = 1'b1;
        if (diff > DIF_MAX)
        begin
            rate_val = V_MAX;
        end
        else if (diff < DIF_MIN)
        begin
            rate_val = V_MIN;
        end
        else
        begin
            rate_val = diff[VB-1:0];
            rate_sat = 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                v_reg    <= start_of_chain ? head_linear_velocity : cv_reg;
                w_reg    <= start_of_chain ? head_angular_velocity : cw_reg;
                eoc_reg  <= end_of_chain;
                sat_reg  <= 1'b0;
                flip_reg <= z_load[31] ^ z_load[30];
                z_reg    <= {z_load[31] ^ (z_load[31] ^ z_load[30]), z_load[30:0]};
                x_reg    <= CORDIC_GAIN;
                y_reg    <= '0;
            end
            OP_ROT:
            begin
                if (!z_reg[31])
                begin
                    x_reg <= x_reg - y_sh;
                    y_reg <= y_reg + x_sh;
                    z_reg <= z_reg - ATAN_TURN[cmd.step];
                end
                else
                begin
                    x_reg <= x_reg + y_sh;
                    y_reg <= y_reg - x_sh;
                    z_reg <= z_reg + ATAN_TURN[cmd.step];
                end
            end
            OP_TRIG:
            begin
                c_reg <= c_new;
                s_reg <= s_new;
            end
            OP_MUL:
            begin
                prod_reg <= prod_next;
                case (cmd.step)
                    STEP_W'(2): acc_reg <= -prod_ext;
                    STEP_W'(3): acc_reg <= acc_reg - (prod_ext <<< FRAC_BITS);
                    STEP_W'(4):
                    begin
                        next_reg <= rnd_val;
                        sat_reg  <= sat_reg | rnd_sat;
                        acc_reg  <= prod_ext <<< FRAC_BITS;
                    end
                    STEP_W'(6): acc_reg <= acc_reg - prod_ext;
                    default: acc_reg <= acc_reg;
                endcase
            end
            OP_FINISH:
            begin
                orate_reg <= rate_val;
                odone_reg <= eoc_reg;
                osat_reg  <= sat_reg | rnd_sat | rate_sat;
            end
            default:
            begin
                x_reg <= x_reg;
            end
        endcase
    end

    // carried state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg     <= '0;
            cw_reg     <= '0;
            ovalid_reg <= 1'b0;
        end
        else if (cmd.op == OP_FINISH)
        begin
            cv_reg     <= rnd_val;
            cw_reg     <= next_reg;
            ovalid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    assign status.out_free = !ovalid_reg || out_ready;
    assign out_valid       = ovalid_reg;
    assign joint_rate      = orate_reg;
    assign chain_done      = odone_reg;
    assign saturated       = osat_reg;

endmodule

// ===== design/snake_joint_rate_propagation.sv =====
// The block takes one item at a time: it runs the 16-step CORDIC rotator, then
// seven steps of the single shared multiplier, and waits while the output register
// is full, before it accepts the next item.
// A finished result waits in the output register while the next beat enters.
// Reset (rst_n low, asynchronous): control idles, the carried velocities
// clear to zero and the link registers return to their default values.
module snake_joint_rate_propagation #(
    parameter int ANGLE_BITS    = 16,
    parameter int VELOCITY_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    sjrp_in_if.sink     joint_in,
    sjrp_out_if.source  rate_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sjrp_pkg::*;

    logic [15:0]  half_link_reg;
    logic [15:0]  inverse_half_reg;
    sjrp_cmd_t    cmd;
    sjrp_status_t status;
    sjrp_reg_t    reg_sel;

    // Configuration: two 16-bit registers, written in the APB access phase.
    assign pready  = 1'b1;
    assign reg_sel = sjrp_reg_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_link_reg    <= HALF_LINK_RESET;
            inverse_half_reg <= INVERSE_HALF_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_sel)
                REG_HALF_LINK:    half_link_reg    <= pwdata[15:0];
                REG_INVERSE_HALF: inverse_half_reg <= pwdata[15:0];
                default:          half_link_reg    <= half_link_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_HALF_LINK:    prdata = {16'd0, half_link_reg};
            REG_INVERSE_HALF: prdata = {16'd0, inverse_half_reg};
            default:          prdata = '0;
        endcase
    end

    // Sequencer: takes one beat, then steps the rotator and the multiplier.
    sjrp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (joint_in.valid),
        .in_ready (joint_in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: CORDIC sine/cosine, shared multiplier, rounding, output register.
    sjrp_datapath #(
        .ANGLE_BITS    (ANGLE_BITS),
        .VELOCITY_BITS (VELOCITY_BITS)
    ) u_datapath (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cmd                   (cmd),
        .status                (status),
        .head_linear_velocity  (joint_in.head_linear_velocity),
        .head_angular_velocity (joint_in.head_angular_velocity),
        .joint_angle           (joint_in.joint_angle),
        .start_of_chain        (joint_in.start_of_chain),
        .end_of_chain          (joint_in.end_of_chain),
        .half_link_length      (half_link_reg),
        .inverse_half_link     (inverse_half_reg),
        .out_valid             (rate_out.valid),
        .out_ready             (rate_out.ready),
        .joint_rate            (rate_out.joint_rate),
        .chain_done            (rate_out.chain_done),
        .saturated             (rate_out.saturated)
    );

endmodule

// ===== tb/sjrp_tb_if.sv =====
`timescale 1ns / 1ps

// Handshake monitor helpers are not needed: the design interfaces are used directly.
// This file holds the APB driver bundle for the configuration port.
interface sjrp_apb_if;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    modport source (output psel, penable, pwrite, paddr, pwdata, input prdata, pready);
    modport sink (input psel, penable, pwrite, paddr, pwdata, output prdata, pready);
endinterface

// ===== tb/snake_joint_rate_propagation_test.sv =====
`timescale 1ns / 1ps

module snake_joint_rate_propagation_test;
    import sjrp_pkg::*;

    localparam int VB = 24;
    localparam int AB = 16;

    typedef struct {
        logic signed [VB-1:0] rate;
        logic                 done;
        logic                 sat;
    } rate_beat_t;

    // Joint rate predictor: carried velocities, link registers, and the queue of
    // expected rate beats.
    class rate_scoreboard;
        longint     half_link;
        longint     inv_half;
        longint     carried_v;
        longint     carried_w;
        rate_beat_t pending_rates[$];
        int         errors;

        function new();
            half_link = HALF_LINK_RESET;
            inv_half  = INVERSE_HALF_RESET;
            carried_v = 0;
            carried_w = 0;
            errors    = 0;
        endfunction

        function longint floor_shift(longint v, int s);
            return v >>> s;
        endfunction

        function longint clip(longint v, ref bit flag);
            longint hi;
            longint lo;
            hi = (64'sd1 <<< (VB - 1)) - 1;
            lo = -hi - 1;
            if (v > hi)
            begin
                flag = 1;
                return hi;
            end
            if (v < lo)
            begin
                flag = 1;
                return lo;
            end
            return v;
        endfunction

        // Rotate a Q24 unit vector through the angle, folding by a half turn.
        function void trig(logic signed [AB-1:0] ang, output longint s, output longint c);
            logic signed [31:0] z32;
            longint z;
            longint x;
            longint y;
            longint nx;
            bit     flip;
            z32  = {ang, {(32 - AB){1'b0}}};
            z    = z32;
            x    = CORDIC_GAIN;
            y    = 0;
            flip = 0;
            if (z >= (64'sd1 <<< 30))
            begin
                z -= 64'sd1 <<< 31;
                flip = 1;
            end
            else if (z < -(64'sd1 <<< 30))
            begin
                z += 64'sd1 <<< 31;
                flip = 1;
            end
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                if (z >= 0)
                begin
                    nx = x - floor_shift(y, i);
                    y  = y + floor_shift(x, i);
                    z -= ATAN_TURN[i];
                end
                else
                begin
                    nx = x + floor_shift(y, i);
                    y  = y - floor_shift(x, i);
                    z += ATAN_TURN[i];
                end
                x = nx;
            end
            x = floor_shift(x + 2048, 12);
            y = floor_shift(y + 2048, 12);
            if (flip)
            begin
                x = -x;
                y = -y;
            end
            c = x;
            s = y;
        endfunction

        function void note_joint(logic signed [VB-1:0] hv, logic signed [VB-1:0] hw,
                                 logic signed [AB-1:0] ang, logic soc, logic eoc);
            longint v;
            longint w;
            longint s;
            longint c;
            longint nxt;
            longint vn;
            longint r;
            bit     sat;
            rate_beat_t b;
            sat = 0;
            if (soc)
            begin
                v = hv;
                w = hw;
            end
            else
            begin
                v = carried_v;
                w = carried_w;
            end
            trig(ang, s, c);
            nxt = clip(floor_shift(-(inv_half * v * s) - w * (c + 4096) * 4096
                                   + (64'sd1 <<< 23), 24), sat);
            vn  = clip(floor_shift(v * c * 4096 - half_link * w * s
                                   + (64'sd1 <<< 23), 24), sat);
            r   = clip(nxt - w, sat);
            carried_w = nxt;
            carried_v = vn;
            b.rate = r[VB-1:0];
            b.done = eoc;
            b.sat  = sat;
            pending_rates.push_back(b);
        endfunction

        function void check_rate(logic signed [VB-1:0] rate, logic done, logic sat);
            rate_beat_t e;
            if (pending_rates.size() == 0)
            begin
                $display("%0t: unexpected rate beat rate=%0d done=%0b sat=%0b",
                         $time, rate, done, sat);
                errors++;
                return;
            end
            e = pending_rates.pop_front();
            if (e.rate !== rate)
            begin
                $display("%0t: joint_rate expected %0d actual %0d", $time, e.rate, rate);
                errors++;
            end
            if (e.done !== done)
            begin
                $display("%0t: chain_done expected %0b actual %0b", $time, e.done, done);
                errors++;
            end
            if (e.sat !== sat)
            begin
                $display("%0t: saturated expected %0b actual %0b", $time, e.sat, sat);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    sjrp_in_if  #(.ANGLE_BITS(AB), .VELOCITY_BITS(VB)) joint_in ();
    sjrp_out_if #(.VELOCITY_BITS(VB))                  rate_out ();
    sjrp_apb_if                                        apb ();

    snake_joint_rate_propagation #(.ANGLE_BITS(AB), .VELOCITY_BITS(VB)) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .joint_in (joint_in.sink),
        .rate_out (rate_out.source),
        .psel     (apb.psel),
        .penable  (apb.penable),
        .pwrite   (apb.pwrite),
        .paddr    (apb.paddr),
        .pwdata   (apb.pwdata),
        .prdata   (apb.prdata),
        .pready   (apb.pready)
    );

    rate_scoreboard sb;

    // Percent chances of idling on each side; the phases below change them.
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_off_cycles;

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // Hard limit: well above the slowest run, stalls included.
    initial
    begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // Receiver: stall at random, or hold off for a long stretch when asked, so
    // the block backs up and drops its input ready.
    initial
    begin
        rate_out.ready = 0;
        forever
        begin
            @(posedge clk);
            if (rate_out.valid && rate_out.ready && rst_n)
                sb.check_rate(rate_out.joint_rate, rate_out.chain_done, rate_out.saturated);
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles--;
                rate_out.ready <= 0;
            end
            else
                rate_out.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one joint beat, idling first at random, and hold it until accepted.
    task automatic send_joint(logic signed [VB-1:0] hv, logic signed [VB-1:0] hw,
                              logic signed [AB-1:0] ang, logic soc, logic eoc);
        while ($urandom_range(99) < send_idle_pct)
        begin
            joint_in.valid <= 0;
            @(posedge clk);
        end
        joint_in.valid                 <= 1;
        joint_in.head_linear_velocity  <= hv;
        joint_in.head_angular_velocity <= hw;
        joint_in.joint_angle           <= ang;
        joint_in.start_of_chain        <= soc;
        joint_in.end_of_chain          <= eoc;
        do
            @(posedge clk);
        while (!joint_in.ready);
        sb.note_joint(hv, hw, ang, soc, eoc);
    endtask

    task automatic drop_valid();
        joint_in.valid <= 0;
    endtask

    // Wait until every expected rate has arrived, then past the latency.
    task automatic drain();
        drop_valid();
        while (sb.pending_rates.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Setup cycle then access cycle; the register takes the value on the access edge.
    task automatic write_link_reg(sjrp_reg_t idx, logic [15:0] value);
        apb.psel    <= 1;
        apb.penable <= 0;
        apb.pwrite  <= 1;
        apb.paddr   <= 3'(idx) << 2;
        apb.pwdata  <= {16'd0, value};
        @(posedge clk);
        apb.penable <= 1;
        @(posedge clk);
        apb.psel    <= 0;
        apb.penable <= 0;
        apb.pwrite  <= 0;
        if (idx == REG_HALF_LINK)
            sb.half_link = value;
        else
            sb.inv_half = value;
        @(posedge clk);
    endtask

    task automatic set_links(logic [15:0] half, logic [15:0] inv);
        drain();
        write_link_reg(REG_HALF_LINK, half);
        write_link_reg(REG_INVERSE_HALF, inv);
    endtask

    // A chain of the given length with random content; a small share of beats is noise.
    task automatic random_chain(int unsigned vel_bits, int unsigned len);
        logic signed [VB-1:0] hv;
        logic signed [VB-1:0] hw;
        hv  = $signed(VB'($urandom)) >>> $urandom_range(VB - 1, 24 - vel_bits);
        hw  = $signed(VB'($urandom)) >>> $urandom_range(VB - 1, 24 - vel_bits);
        for (int i = 0; i < len; i++)
        begin
            logic soc;
            logic eoc;
            soc = (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0);
            eoc = (i == len - 1) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0);
            send_joint(soc ? hv : VB'($urandom), soc ? hw : VB'($urandom),
                       AB'($urandom), soc, eoc);
        end
    endtask

    task automatic random_phase(int unsigned n, int unsigned idle, int unsigned stall);
        int unsigned sent;
        int unsigned len;
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        sent = 0;
        while (sent < n)
        begin
            len = $urandom_range(1, 8);
            random_chain($urandom_range(0, 1) ? 24 : 12, len);
            sent += len;
        end
    endtask

    localparam logic signed [VB-1:0] VMAX = {1'b0, {(VB - 1){1'b1}}};
    localparam logic signed [VB-1:0] VMIN = {1'b1, {(VB - 1){1'b0}}};
    localparam logic signed [AB-1:0] AMAX = {1'b0, {(AB - 1){1'b1}}};
    localparam logic signed [AB-1:0] AMIN = {1'b1, {(AB - 1){1'b0}}};

    initial
    begin
        sb              = new();
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 0;
        rst_n           = 0;
        joint_in.valid  = 0;
        joint_in.head_linear_velocity  = 0;
        joint_in.head_angular_velocity = 0;
        joint_in.joint_angle           = 0;
        joint_in.start_of_chain        = 0;
        joint_in.end_of_chain          = 0;
        apb.psel    = 0;
        apb.penable = 0;
        apb.pwrite  = 0;
        apb.paddr   = 0;
        apb.pwdata  = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: no start after reset runs from zero carried values.
        send_joint(24'sd4096, 24'sd4096, 16'sd8192, 0, 0);
        // Chain with quarter and half turn angles and the fold boundaries.
        send_joint(24'sd40960, 24'sd2048, 16'sd0, 1, 0);
        send_joint(0, 0, 16'sd16384, 0, 0);
        send_joint(0, 0, -16'sd16384, 0, 0);
        send_joint(0, 0, AMIN, 0, 0);
        send_joint(0, 0, AMAX, 0, 1);
        // Continue after end without start: carried values persist.
        send_joint(0, 0, 16'sd1000, 0, 0);
        send_joint(0, 0, -16'sd1000, 0, 1);
        // Extremes of the head velocities: saturation.
        send_joint(VMAX, VMAX, 16'sd12000, 1, 1);
        send_joint(VMIN, VMIN, -16'sd12000, 1, 0);
        send_joint(VMIN, VMAX, 16'sd0, 1, 0);
        send_joint(VMAX, VMIN, AMIN, 1, 1);
        send_joint(-24'sd1, 24'sd1, 16'sd1, 1, 1);

        // Zero registers: the products with the link registers vanish.
        set_links(16'd0, 16'd0);
        send_joint(24'sd50000, 24'sd30000, 16'sd5000, 1, 0);
        send_joint(0, 0, -16'sd7000, 0, 1);
        // Largest registers.
        set_links(16'hFFFF, 16'hFFFF);
        send_joint(24'sd50000, -24'sd30000, 16'sd5000, 1, 0);
        send_joint(0, 0, 16'sd20000, 0, 1);
        send_joint(VMAX, VMIN, 16'sd3000, 1, 1);

        set_links(16'd1024, 16'd16384);
        random_phase(250, 0, 0);

        // Long receiver hold-off while the sender keeps offering beats.
        hold_off_cycles = 400;
        random_phase(100, 0, 0);

        set_links(16'd2048, 16'd8192);
        random_phase(250, 45, 0);
        set_links(16'd512, 16'd32768);
        random_phase(250, 0, 45);
        set_links(16'($urandom), 16'($urandom));
        random_phase(250, 17, 17);

        drain();
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== sim.f =====
design/sjrp_pkg.sv
design/sjrp_if.sv
design/sjrp_ctrl.sv
design/sjrp_datapath.sv
design/snake_joint_rate_propagation.sv
tb/sjrp_tb_if.sv
tb/snake_joint_rate_propagation_test.sv
